/* rtl/rgb_pixel_point_operator_core_assert.svh */
// Assertion macros for the RGB pixel point operator.
// Used by the port checker; no other dependencies.
`ifndef RGB_PIXEL_POINT_OPERATOR_CORE_ASSERT_SVH
`define RGB_PIXEL_POINT_OPERATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RPO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rpo assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RPO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rpo assertion failed");

`endif

/* rtl/rpo_pkg.sv */
// Shared types and constants for the RGB pixel point operator.
// No dependencies.
package rpo_pkg;

  localparam int PIX_W      = 8;
  localparam int FACTOR_W   = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [2:0] {
    MODE_LUMA    = 3'd0,
    MODE_AVERAGE = 3'd1,
    MODE_RED     = 3'd2,
    MODE_GREEN   = 3'd3,
    MODE_BLUE    = 3'd4,
    MODE_BOOST   = 3'd5,
    MODE_THRESH  = 3'd6,
    MODE_INVERT  = 3'd7
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST  = 2'd2;

  localparam logic [FACTOR_W-1:0] BOOST_RESET = 12'd256;

  localparam logic [15:0] LUMA_WR = 16'd19595;
  localparam logic [15:0] LUMA_WG = 16'd38470;
  localparam logic [15:0] LUMA_WB = 16'd7471;

  // x / 3 == (x * 683) >> 11 for x up to 765
  localparam logic [9:0] AVG_RECIP = 10'd683;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

/* rtl/rpo_boost_lane.sv */
// One channel of the boost operation: Q4.8 gain, truncate, wrap modulo 255.
// Two register stages; the wrap feeds the caller's output register. Depends on rpo_pkg.
module rpo_boost_lane (
  input  logic                            clk_i,
  input  rpo_pkg::stage_en_t              stage_en_i,
  input  logic [rpo_pkg::PIX_W-1:0]       chan_i,
  input  logic [rpo_pkg::FACTOR_W-1:0]    factor_i,
  output logic [rpo_pkg::PIX_W-1:0]       chan_o
);
  import rpo_pkg::*;

  logic [19:0] prod_q;
  logic [8:0]  fold_d, fold_q;
  logic [7:0]  res_d;

  // 256 == 1 mod 255: add the high nibble and low byte of the truncated product
  assign fold_d = 9'(prod_q[19:16]) + 9'(prod_q[15:8]);
  assign res_d  = (fold_q >= 9'd255) ? 8'(fold_q - 9'd255) : fold_q[7:0];

  always_ff @(posedge clk_i) begin
    if (stage_en_i.s1) begin
      prod_q <= 20'(chan_i) * 20'(factor_i);
    end
    if (stage_en_i.s2) begin
      fold_q <= fold_d;
    end
  end

  assign chan_o = res_d;

endmodule

/* rtl/rgb_pixel_point_operator_core.sv */
// RGB pixel point operator: luma, average, channel keep, boost, threshold, invert.
// Registered from input word to output word; throughput one word per cycle while out_ready_i does not stall the output.
// Stages: products and channel sum, luma sum with reciprocal multiply and fold, wrap and mode select.
// Async active-low reset clears valid bits and restores mode 0, threshold 0,
// boost factor 1.0. Depends on rpo_pkg and rpo_boost_lane.
module rgb_pixel_point_operator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rpo_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rpo_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rpo_pkg::PIX_W-1:0]         red_in_i,
  input  logic [rpo_pkg::PIX_W-1:0]         green_in_i,
  input  logic [rpo_pkg::PIX_W-1:0]         blue_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rpo_pkg::PIX_W-1:0]         red_out_o,
  output logic [rpo_pkg::PIX_W-1:0]         green_out_o,
  output logic [rpo_pkg::PIX_W-1:0]         blue_out_o
);
  import rpo_pkg::*;

  mode_e               mode_q;
  logic [PIX_W-1:0]    thresh_q;
  logic [FACTOR_W-1:0] factor_q;

  logic      v1_q, v2_q, v3_q;
  stage_en_t en;

  logic [PIX_W-1:0] r1_q, g1_q, b1_q, r2_q, g2_q, b2_q;
  logic [23:0]      lr1_q, lg1_q, lb1_q;
  logic [9:0]       sum1_q;
  logic [23:0]      lsum_d;
  logic [PIX_W-1:0] luma2_q;
  logic [19:0]      avgp2_q;
  logic [PIX_W-1:0] boost_r, boost_g, boost_b;
  logic [PIX_W-1:0] ro_d, go_d, bo_d, ro_q, go_q, bo_q;
  logic [PIX_W-1:0] avg;

  assign en.s3 = !v3_q || out_ready_i;
  assign en.s2 = !v2_q || en.s3;
  assign en.s1 = !v1_q || en.s2;

  assign in_ready_o = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_LUMA;
      thresh_q <= '0;
      factor_q <= BOOST_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:   mode_q   <= mode_e'(cfg_wdata_i[2:0]);
        CFG_THRESH: thresh_q <= cfg_wdata_i[PIX_W-1:0];
        CFG_BOOST:  factor_q <= cfg_wdata_i[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= in_valid_i;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
    end
  end

  assign lsum_d = lr1_q + lg1_q + lb1_q;

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      r1_q   <= red_in_i;
      g1_q   <= green_in_i;
      b1_q   <= blue_in_i;
      lr1_q  <= 24'(LUMA_WR) * 24'(red_in_i);
      lg1_q  <= 24'(LUMA_WG) * 24'(green_in_i);
      lb1_q  <= 24'(LUMA_WB) * 24'(blue_in_i);
      sum1_q <= 10'(red_in_i) + 10'(green_in_i) + 10'(blue_in_i);
    end
    if (en.s2) begin
      r2_q    <= r1_q;
      g2_q    <= g1_q;
      b2_q    <= b1_q;
      luma2_q <= lsum_d[23:16];
      avgp2_q <= 20'(sum1_q) * 20'(AVG_RECIP);
    end
    if (en.s3) begin
      ro_q <= ro_d;
      go_q <= go_d;
      bo_q <= bo_d;
    end
  end

  rpo_boost_lane u_boost_r (
    .clk_i      (clk_i),
    .stage_en_i (en),
    .chan_i     (red_in_i),
    .factor_i   (factor_q),
    .chan_o     (boost_r)
  );

  rpo_boost_lane u_boost_g (
    .clk_i      (clk_i),
    .stage_en_i (en),
    .chan_i     (green_in_i),
    .factor_i   (factor_q),
    .chan_o     (boost_g)
  );

  rpo_boost_lane u_boost_b (
    .clk_i      (clk_i),
    .stage_en_i (en),
    .chan_i     (blue_in_i),
    .factor_i   (factor_q),
    .chan_o     (boost_b)
  );

  assign avg = avgp2_q[18:11];

  always_comb begin
    ro_d = '0;
    go_d = '0;
    bo_d = '0;
    unique case (mode_q)
      MODE_LUMA: begin
        ro_d = luma2_q;
        go_d = luma2_q;
        bo_d = luma2_q;
      end
      MODE_AVERAGE: begin
        ro_d = avg;
        go_d = avg;
        bo_d = avg;
      end
      MODE_RED:   ro_d = r2_q;
      MODE_GREEN: go_d = g2_q;
      MODE_BLUE:  bo_d = b2_q;
      MODE_BOOST: begin
        ro_d = boost_r;
        go_d = boost_g;
        bo_d = boost_b;
      end
      MODE_THRESH: begin
        ro_d = (luma2_q > thresh_q) ? PIX_MAX : '0;
        go_d = ro_d;
        bo_d = ro_d;
      end
      MODE_INVERT: begin
        ro_d = PIX_MAX - r2_q;
        go_d = PIX_MAX - g2_q;
        bo_d = PIX_MAX - b2_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = v3_q;
  assign red_out_o   = ro_q;
  assign green_out_o = go_q;
  assign blue_out_o  = bo_q;

endmodule

/* rtl/rpo_checker.sv */
// Port-level checker for the RGB pixel point operator, bound to the top level.
// Depends on rpo_pkg and rgb_pixel_point_operator_core_assert.svh.
`include "rgb_pixel_point_operator_core_assert.svh"

module rpo_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [rpo_pkg::PIX_W-1:0]         red_out_o,
  input logic [rpo_pkg::PIX_W-1:0]         green_out_o,
  input logic [rpo_pkg::PIX_W-1:0]         blue_out_o
);
  import rpo_pkg::*;

  logic in_fire;
  logic out_stall;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  `RPO_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall,
                  out_valid_o && $stable(red_out_o) && $stable(green_out_o)
                  && $stable(blue_out_o))

  `RPO_ASSERT_IMP(a_ready_when_drained, clk_i, rst_ni, out_ready_i, in_ready_o)

  `RPO_ASSERT_NXT(a_latency, clk_i, rst_ni,
                  in_fire ##1 out_ready_i ##1 out_ready_i, out_valid_o)

  `RPO_ASSERT_NXT(a_cfg_idle_out, clk_i, rst_ni,
                  !in_fire && !out_valid_o && out_ready_i ##1 !in_fire
                  && out_ready_i ##1 !in_fire && out_ready_i, !out_valid_o)

endmodule

bind rgb_pixel_point_operator_core rpo_checker u_rpo_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench for rgb_pixel_point_operator_core: directed and random pixel words under
// random source and sink stalls, checked against an in-file model. Uses rpo_pkg and the DUT.
module tb;
  import rpo_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int RANDOM_PHASES    = 12;
  localparam int PIXELS_PER_PHASE = 40;
  localparam int DRAIN_LIMIT      = 1000;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  class point_op_model;
    mode_e               mode;
    logic [PIX_W-1:0]    thresh;
    logic [FACTOR_W-1:0] gain;
    pixel_t              expected_q[$];
    int                  checked;
    int                  mismatches;

    function new();
      mode       = MODE_LUMA;
      thresh     = '0;
      gain       = BOOST_RESET;
      checked    = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MODE:   mode = mode_e'(data[2:0]);
        CFG_THRESH: thresh = data[PIX_W-1:0];
        CFG_BOOST:  gain = data[FACTOR_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PIX_W-1:0] luma(pixel_t p);
      logic [31:0] acc;
      acc = 32'(LUMA_WR) * 32'(p.red) + 32'(LUMA_WG) * 32'(p.green)
          + 32'(LUMA_WB) * 32'(p.blue);
      return acc[23:16];
    endfunction

    function logic [PIX_W-1:0] boosted(logic [PIX_W-1:0] c);
      logic [19:0] prod;
      prod = 20'(c) * 20'(gain);
      return PIX_W'((prod >> 8) % 20'd255);
    endfunction

    function pixel_t transform(pixel_t p);
      logic [9:0]       sum;
      logic [PIX_W-1:0] gray;
      pixel_t           q;
      q   = '0;
      sum = 10'(p.red) + 10'(p.green) + 10'(p.blue);
      case (mode)
        MODE_LUMA: begin
          gray = luma(p);
          q    = {gray, gray, gray};
        end
        MODE_AVERAGE: begin
          gray = PIX_W'(sum / 10'd3);
          q    = {gray, gray, gray};
        end
        MODE_RED:   q.red = p.red;
        MODE_GREEN: q.green = p.green;
        MODE_BLUE:  q.blue = p.blue;
        MODE_BOOST: q = {boosted(p.red), boosted(p.green), boosted(p.blue)};
        MODE_THRESH: begin
          gray = (luma(p) > thresh) ? PIX_MAX : '0;
          q    = {gray, gray, gray};
        end
        default: q = {PIX_MAX - p.red, PIX_MAX - p.green, PIX_MAX - p.blue};
      endcase
      return q;
    endfunction

    function void note_pixel(pixel_t p);
      expected_q.push_back(transform(p));
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_q.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] output word %06h with no pixel outstanding", $time, got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        if (mismatches < 10)
          $display("[%0t] %s: expected r %02h g %02h b %02h, got r %02h g %02h b %02h",
                   $time, mode.name(), want.red, want.green, want.blue,
                   got.red, got.green, got.blue);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [PIX_W-1:0]      red_in_i;
  logic [PIX_W-1:0]      green_in_i;
  logic [PIX_W-1:0]      blue_in_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [PIX_W-1:0]      red_out_o;
  logic [PIX_W-1:0]      green_out_o;
  logic [PIX_W-1:0]      blue_out_o;

  point_op_model model = new();
  bit            idle_free;
  int            pixels_per_mode[8];
  int            settings_used;

  rgb_pixel_point_operator_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        model.note_pixel({red_in_i, green_in_i, blue_in_i});
        pixels_per_mode[model.mode]++;
      end
      if (out_valid_o && out_ready_i)
        model.check_pixel({red_out_o, green_out_o, blue_out_o});
    end
  end

  initial begin : sink
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_free ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_pixel(pixel_t p);
    int gap;
    gap = idle_free ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i   <= p.red;
    green_in_i <= p.green;
    blue_in_i  <= p.blue;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (model.expected_q.size() != 0 && waited < DRAIN_LIMIT);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    model.write_reg(idx, data);
  endtask

  function automatic logic [CFG_DATA_W-1:0] mode_word(mode_e m);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    return {noise[CFG_DATA_W-1:3], m};
  endfunction

  task automatic select_mode(mode_e m);
    drain();
    write_reg(CFG_MODE, mode_word(m));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] random_channel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return PIX_MAX;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] noise;
    logic [PIX_W-1:0]      th;
    logic [FACTOR_W-1:0]   g;
    mode_e                 m;
    int                    first;
    int                    reg_sel;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    red_in_i    = '0;
    green_in_i  = '0;
    blue_in_i   = '0;
    idle_free   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_pixel({8'h00, 8'h00, 8'h00});
    send_pixel({8'hFF, 8'hFF, 8'hFF});
    send_pixel({8'h80, 8'h40, 8'h7F});
    select_mode(MODE_BOOST);
    send_pixel({8'hFF, 8'h80, 8'h01});
    select_mode(MODE_THRESH);
    send_pixel({8'h00, 8'h00, 8'h00});
    send_pixel({8'h01, 8'h01, 8'h01});
    drain();
    write_reg(CFG_THRESH, 12'hF80);
    cfg_we_i <= 1'b0;
    send_pixel({8'h80, 8'h80, 8'h80});
    send_pixel({8'h81, 8'h81, 8'h81});
    select_mode(MODE_AVERAGE);
    send_pixel({8'hFF, 8'hFF, 8'hFF});
    send_pixel({8'h02, 8'h01, 8'h00});
    select_mode(MODE_RED);
    send_pixel({8'hA5, 8'h5A, 8'hC3});
    select_mode(MODE_GREEN);
    send_pixel({8'hA5, 8'h5A, 8'hC3});
    select_mode(MODE_BLUE);
    send_pixel({8'hA5, 8'h5A, 8'hC3});
    drain();
    write_reg(CFG_BOOST, 12'hFFF);
    write_reg(CFG_MODE, mode_word(MODE_BOOST));
    cfg_we_i <= 1'b0;
    send_pixel({8'hFF, 8'h00, 8'h01});
    drain();
    write_reg(CFG_BOOST, 12'h000);
    cfg_we_i <= 1'b0;
    send_pixel({8'hFF, 8'hFF, 8'hFF});
    select_mode(MODE_INVERT);
    send_pixel({8'h00, 8'hFF, 8'h5A});
    drain();
    write_reg(CFG_SPARE, 12'h000);
    cfg_we_i <= 1'b0;
    send_pixel({8'h00, 8'hFF, 8'h5A});
    settings_used = 12;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      m  = (ph < 8) ? mode_e'(ph) : (ph[0] ? MODE_THRESH : MODE_BOOST);
      th = (ph == 6) ? 8'h00 : (ph == 9) ? 8'hFF : PIX_W'($urandom_range(0, 255));
      g  = (ph == 5) ? 12'hFFF : (ph == 8) ? 12'h000 : FACTOR_W'($urandom_range(0, 4095));
      drain();
      first = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        noise   = CFG_DATA_W'($urandom);
        reg_sel = (first + k) % 3;
        case (reg_sel)
          0:       write_reg(CFG_MODE, mode_word(m));
          1:       write_reg(CFG_THRESH, {noise[CFG_DATA_W-1:PIX_W], th});
          default: write_reg(CFG_BOOST, g);
        endcase
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
      cfg_we_i <= 1'b0;
      settings_used++;
      idle_free = (ph % 4 == 3);
      for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
        send_pixel({random_channel(), random_channel(), random_channel()});
        if (!idle_free && $urandom_range(0, 29) == 0)
          drain();
      end
      idle_free = 1'b0;
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (model.expected_q.size() != 0) begin
      $display("%0d expected output words never arrived", model.expected_q.size());
      model.mismatches += model.expected_q.size();
    end

    $display("%0d output words checked over %0d register settings, %0d mismatches",
             model.checked, settings_used, model.mismatches);
    $display("words per mode luma/avg/red/green/blue/boost/thresh/invert: %0d %0d %0d %0d %0d %0d %0d %0d",
             pixels_per_mode[0], pixels_per_mode[1], pixels_per_mode[2], pixels_per_mode[3],
             pixels_per_mode[4], pixels_per_mode[5], pixels_per_mode[6], pixels_per_mode[7]);
    if (model.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/rpo_pkg.sv
rtl/rpo_boost_lane.sv
rtl/rgb_pixel_point_operator_core.sv
rtl/rpo_checker.sv
verif/tb.sv
